// File: rtl/core/cpfa_pkg.sv
// Package: shared constants and types for the contiguous page frame allocator.
package cpfa_pkg;
	localparam int NUM_FRAMES = 4096;
	localparam int MAX_RUN = 64;
	localparam int FRAME_W = $clog2(NUM_FRAMES);
	localparam int WORD_W = 32;
	localparam int NUM_WORDS = NUM_FRAMES / WORD_W;
	localparam int WADDR_W = $clog2(NUM_WORDS);
	localparam int BIT_W = $clog2(WORD_W);
	localparam int LEN_W = 7;
	localparam int RES_W = 13;
	localparam int CNT_W = $clog2(MAX_RUN + 1);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_UNALLOC = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE = 1'b1;

	typedef struct packed {
		logic we;
		logic [WADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic [WADDR_W-1:0] raddr;
	} map_req_t;

	typedef struct packed {
		logic we;
		logic [FRAME_W-1:0] waddr;
		logic [LEN_W-1:0] wdata;
		logic [FRAME_W-1:0] raddr;
	} run_req_t;
endpackage

// File: rtl/core/cpfa_map_ram.sv
// Free map memory: one bit per frame, 32 frames per word, registered read.
module cpfa_map_ram (
	input  logic clk,
	input  cpfa_pkg::map_req_t req,
	output logic [cpfa_pkg::WORD_W-1:0] rdata
);
	logic [cpfa_pkg::WORD_W-1:0] mem [cpfa_pkg::NUM_WORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end
endmodule

// File: rtl/core/cpfa_run_ram.sv
// Run length memory: recorded run length at each first frame, registered read.
module cpfa_run_ram (
	input  logic clk,
	input  cpfa_pkg::run_req_t req,
	output logic [cpfa_pkg::LEN_W-1:0] rdata
);
	logic [cpfa_pkg::LEN_W-1:0] mem [cpfa_pkg::NUM_FRAMES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end
endmodule

// File: rtl/core/contiguous_page_frame_allocator_core.sv
// Top level: command interface, clearing pass and bit-serial run search over the memories.
//
// After reset the block clears both memories, one map word and one run entry per cycle,
// with busy high. An item is taken when start is high and busy low; its one result
// appears for a single cycle with done high and must be captured then. Each frame
// visited takes a map word read, then a bit test, since there is a single memory port pair.
// An allocate scans up from resv_q for free frames, then sets their map bits and records
// the length; a free reads the recorded length at frame_index, then clears those bits.
module contiguous_page_frame_allocator_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic action,
	input  logic [6:0] run_length,
	input  logic [11:0] frame_index,
	input  logic cfg_we,
	input  logic [12:0] cfg_wdata,
	output logic done,
	output logic [11:0] first_frame,
	output logic [1:0] status
);
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_SRD   = 4'd2;
	localparam logic [3:0] S_STST  = 4'd3;
	localparam logic [3:0] S_MRD   = 4'd4;
	localparam logic [3:0] S_MWR   = 4'd5;
	localparam logic [3:0] S_FRD   = 4'd6;
	localparam logic [3:0] S_FCHK  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	localparam int FW = cpfa_pkg::FRAME_W;

	logic [3:0] state_q;
	logic [FW:0] frame_q;
	logic [FW:0] start_q;
	logic [FW-1:0] clr_q;
	logic [cpfa_pkg::CNT_W-1:0] count_q;
	logic [cpfa_pkg::LEN_W-1:0] len_q;
	logic act_q;
	logic set_q;
	logic [cpfa_pkg::RES_W-1:0] resv_q;
	logic [FW-1:0] res_frame_q;
	logic [1:0] res_status_q;
	logic done_q;

	cpfa_pkg::map_req_t map_req;
	cpfa_pkg::run_req_t run_req;
	logic [cpfa_pkg::WORD_W-1:0] map_rdata;
	logic [cpfa_pkg::LEN_W-1:0] run_rdata;
	logic cur_bit;

	cpfa_map_ram u_map (.clk(clk), .req(map_req), .rdata(map_rdata));
	cpfa_run_ram u_run (.clk(clk), .req(run_req), .rdata(run_rdata));

	assign cur_bit = map_rdata[frame_q[cpfa_pkg::BIT_W-1:0]];

	always_comb begin
		map_req = '0;
		run_req = '0;
		map_req.raddr = frame_q[FW-1:cpfa_pkg::BIT_W];
		run_req.raddr = frame_q[FW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				map_req.we = 1'b1;
				map_req.waddr = clr_q[cpfa_pkg::WADDR_W-1:0];
				run_req.we = 1'b1;
				run_req.waddr = clr_q;
			end
			S_MWR: begin
				map_req.we = 1'b1;
				map_req.waddr = frame_q[FW-1:cpfa_pkg::BIT_W];
				map_req.wdata = map_rdata;
				map_req.wdata[frame_q[cpfa_pkg::BIT_W-1:0]] = set_q;
			end
			S_FCHK: begin
				run_req.we = (run_rdata != '0);
				run_req.waddr = frame_q[FW-1:0];
				run_req.wdata = '0;
			end
			S_DONE: begin
				run_req.we = ~act_q && (res_status_q == cpfa_pkg::ST_OK);
				run_req.waddr = start_q[FW-1:0];
				run_req.wdata = len_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			resv_q <= '0;
			done_q <= 1'b0;
			frame_q <= '0;
			start_q <= '0;
			count_q <= '0;
			len_q <= '0;
			act_q <= 1'b0;
			set_q <= 1'b0;
			res_frame_q <= '0;
			res_status_q <= cpfa_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				resv_q <= cfg_wdata;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == FW'(cpfa_pkg::NUM_FRAMES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						act_q <= action;
						len_q <= run_length;
						count_q <= '0;
						if (action == cpfa_pkg::ACT_FREE) begin
							frame_q <= {1'b0, frame_index};
							start_q <= {1'b0, frame_index};
							state_q <= S_FRD;
						end else if (run_length == '0 || run_length > cpfa_pkg::LEN_W'(cpfa_pkg::MAX_RUN)
								|| resv_q >= cpfa_pkg::RES_W'(cpfa_pkg::NUM_FRAMES)) begin
							res_frame_q <= '0;
							res_status_q <= cpfa_pkg::ST_NOSPACE;
							state_q <= S_DONE;
						end else begin
							frame_q <= resv_q[FW:0];
							start_q <= resv_q[FW:0];
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: begin
					state_q <= S_STST;
				end
				S_STST: begin
					if (cur_bit) begin
						count_q <= '0;
						start_q <= frame_q + 1'b1;
					end else if (cpfa_pkg::CNT_W'(count_q + 1'b1) == cpfa_pkg::CNT_W'(len_q)) begin
						res_frame_q <= start_q[FW-1:0];
						res_status_q <= cpfa_pkg::ST_OK;
						frame_q <= start_q;
						count_q <= '0;
						set_q <= 1'b1;
						state_q <= S_MRD;
					end else begin
						count_q <= count_q + 1'b1;
					end
					if (cur_bit || cpfa_pkg::CNT_W'(count_q + 1'b1) != cpfa_pkg::CNT_W'(len_q)) begin
						if (frame_q == (FW+1)'(cpfa_pkg::NUM_FRAMES - 1)) begin
							res_frame_q <= '0;
							res_status_q <= cpfa_pkg::ST_NOSPACE;
							state_q <= S_DONE;
						end else begin
							frame_q <= frame_q + 1'b1;
							state_q <= S_SRD;
						end
					end
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					res_frame_q <= frame_q[FW-1:0];
					if (run_rdata == '0) begin
						res_status_q <= cpfa_pkg::ST_UNALLOC;
						state_q <= S_DONE;
					end else begin
						res_status_q <= cpfa_pkg::ST_OK;
						len_q <= run_rdata;
						set_q <= 1'b0;
						state_q <= S_MRD;
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					if (cpfa_pkg::CNT_W'(count_q + 1'b1) == cpfa_pkg::CNT_W'(len_q)
							|| frame_q == (FW+1)'(cpfa_pkg::NUM_FRAMES - 1)) begin
						state_q <= S_DONE;
					end else begin
						count_q <= count_q + 1'b1;
						frame_q <= frame_q + 1'b1;
						state_q <= S_MRD;
					end
				end
				S_DONE: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign first_frame = res_frame_q;
	assign status = res_status_q;
endmodule
